// ===== hdl/sequential_list_engine_defines.svh =====
// ----------------------------------------------------------------------------
// sequential_list_engine_defines.svh
// Assertion macros shared by the list engine's checker.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, idle while reset is held
`define SLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("list engine check failed");

// next-cycle implication, idle while reset is held
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("list engine check failed");

`endif

// ===== hdl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Types, codes and helpers shared by the list engine modules.
// ----------------------------------------------------------------------------
package sle_pkg;

    // default sizing
    localparam int unsigned CAPACITY_DEF   = 16;
    localparam int unsigned DATA_WIDTH_DEF = 32;

    // request function codes
    localparam logic [3:0] FN_PUSH_BACK  = 4'd0;
    localparam logic [3:0] FN_PUSH_FRONT = 4'd1;
    localparam logic [3:0] FN_POP_BACK   = 4'd2;
    localparam logic [3:0] FN_POP_FRONT  = 4'd3;
    localparam logic [3:0] FN_INSERT     = 4'd4;
    localparam logic [3:0] FN_ERASE      = 4'd5;
    localparam logic [3:0] FN_FIND       = 4'd6;
    localparam logic [3:0] FN_MODIFY     = 4'd7;
    localparam logic [3:0] FN_DUMP       = 4'd8;
    localparam logic [3:0] FN_CLEAR      = 4'd9;

    // result status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;
    localparam logic [1:0] STS_RANGE = 2'd3;

    // classified operation as held in the queue
    typedef enum logic [3:0] {
        OP_NOP,
        OP_INS_BACK,
        OP_INS_FRONT,
        OP_INS_POS,
        OP_DEL_BACK,
        OP_DEL_FRONT,
        OP_DEL_POS,
        OP_FIND,
        OP_MODIFY,
        OP_DUMP,
        OP_CLEAR
    } t_op;

    // back end sequencer states
    typedef enum logic {
        BS_RUN,
        BS_DUMP
    } t_bstate;

    // request item
    typedef struct packed {
        logic [3:0]         func;
        logic [3:0]         position;
        logic signed [31:0] value;
    } t_req;

    // result item
    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [3:0]         index;
        logic signed [31:0] data_out;
        logic [4:0]         count;
        logic               last;
    } t_res;

    // queued command
    typedef struct packed {
        t_op                op;
        logic [3:0]         position;
        logic signed [31:0] value;
    } t_cmd;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    // fit a value to the index field
    function automatic logic [3:0] fit_index(input logic [31:0] v);
        return v[3:0];
    endfunction

    // fit a value to the count field
    function automatic logic [4:0] fit_count(input logic [31:0] v);
        return v[4:0];
    endfunction

endpackage

// ===== hdl/sle_front.sv =====
// ----------------------------------------------------------------------------
// sle_front
// Takes request items, classifies the function code and queues the command.
// ----------------------------------------------------------------------------
module sle_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  sle_pkg::t_req i_req,
    output logic          o_busy,
    input  logic          i_pop,
    output sle_pkg::t_qhead o_head
);
    import sle_pkg::*;

    localparam int QDEPTH = 2;

    t_cmd       r_slot [QDEPTH];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_fill;
    t_op        dec_op;
    logic       push;
    logic       pop;

    // function code to operation
    always_comb begin
        unique case (i_req.func)
            FN_PUSH_BACK:  dec_op = OP_INS_BACK;
            FN_PUSH_FRONT: dec_op = OP_INS_FRONT;
            FN_POP_BACK:   dec_op = OP_DEL_BACK;
            FN_POP_FRONT:  dec_op = OP_DEL_FRONT;
            FN_INSERT:     dec_op = OP_INS_POS;
            FN_ERASE:      dec_op = OP_DEL_POS;
            FN_FIND:       dec_op = OP_FIND;
            FN_MODIFY:     dec_op = OP_MODIFY;
            FN_DUMP:       dec_op = OP_DUMP;
            FN_CLEAR:      dec_op = OP_CLEAR;
            default:       dec_op = OP_NOP;
        endcase
    end

    assign o_busy = (r_fill == 2'(QDEPTH));
    assign push   = i_start && !o_busy;
    assign pop    = i_pop && (r_fill != 2'd0);

    // queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= '{op: dec_op, position: i_req.position, value: i_req.value};
        end
    end

    assign o_head.valid = (r_fill != 2'd0);
    assign o_head.cmd   = r_slot[r_rd];

endmodule

// ===== hdl/sle_back.sv =====
// ----------------------------------------------------------------------------
// sle_back
// Cell chain holding the list; carries out one queued command per cycle while no dump is running.
// ----------------------------------------------------------------------------
module sle_back #(
    parameter int unsigned CAPACITY   = sle_pkg::CAPACITY_DEF,
    parameter int unsigned DATA_WIDTH = sle_pkg::DATA_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sle_pkg::t_qhead i_head,
    output logic            o_pop,
    output logic            o_strobe,
    output sle_pkg::t_res   o_res
);
    import sle_pkg::*;

    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int EPW  = (CNTW > 4) ? CNTW : 4;

    logic [DATA_WIDTH-1:0] r_cell [CAPACITY];
    logic [DATA_WIDTH-1:0] n_cell [CAPACITY];
    logic [CNTW-1:0]       r_count;
    logic [CNTW-1:0]       n_count;
    t_bstate               r_state;
    t_bstate               n_state;
    logic [IW-1:0]         r_didx;
    logic [IW-1:0]         n_didx;
    logic                  r_strobe;
    logic                  n_strobe;
    t_res                  r_res;
    t_res                  n_res;

    t_cmd                  cmd;
    logic [DATA_WIDTH-1:0] key;
    logic signed [31:0]    out0;
    logic [EPW-1:0]        pos_e;
    logic [EPW-1:0]        cnt_e;
    logic [EPW-1:0]        ep;
    logic                  full;
    logic                  empty;
    logic                  pos_bad;
    logic [CAPACITY-1:0]   match;
    logic [IW-1:0]         f_idx;
    logic                  do_ins;
    logic                  do_del;
    logic                  do_mod;
    logic                  do_rot;

    assign cmd     = i_head.cmd;
    assign pos_e   = EPW'(cmd.position);
    assign cnt_e   = EPW'(r_count);
    assign full    = (r_count == CNTW'(CAPACITY));
    assign empty   = (r_count == '0);
    assign pos_bad = (pos_e >= cnt_e);

    // item value to stored word, stored word to result field
    generate
        if (DATA_WIDTH > 32) begin : g_key_wide
            assign key = {{(DATA_WIDTH - 32){cmd.value[31]}}, cmd.value};
        end else begin : g_key_narrow
            assign key = cmd.value[DATA_WIDTH-1:0];
        end
        if (DATA_WIDTH >= 32) begin : g_out_wide
            assign out0 = r_cell[0][31:0];
        end else begin : g_out_narrow
            assign out0 = {{(32 - DATA_WIDTH){r_cell[0][DATA_WIDTH-1]}}, r_cell[0]};
        end
    endgenerate

    // key compare in every live cell
    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_match
            assign match[i] = (r_cell[i] == key) && (EPW'(i) < cnt_e);
        end
    endgenerate

    // first match wins
    always_comb begin
        f_idx = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (match[k]) begin
                f_idx = IW'(k);
            end
        end
    end

    // sequencer: next state, command pop and result
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_didx   = r_didx;
        n_strobe = 1'b0;
        o_pop    = 1'b0;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        do_mod   = 1'b0;
        do_rot   = 1'b0;
        ep       = '0;
        n_res    = '0;
        n_res.status = STS_OK;
        n_res.last   = 1'b1;
        unique case (r_state)
            BS_RUN: begin
                if (i_head.valid) begin
                    o_pop    = 1'b1;
                    n_strobe = 1'b1;
                    case (cmd.op) inside
                        OP_INS_BACK, OP_INS_FRONT, OP_INS_POS: begin
                            if (full) begin
                                n_res.status = STS_FULL;
                            end else if (cmd.op == OP_INS_POS && pos_bad) begin
                                n_res.status = STS_RANGE;
                            end else begin
                                do_ins  = 1'b1;
                                n_count = r_count + CNTW'(1);
                                if (cmd.op == OP_INS_BACK) begin
                                    ep = cnt_e;
                                end else if (cmd.op == OP_INS_POS) begin
                                    ep = pos_e;
                                end
                            end
                        end
                        OP_DEL_BACK, OP_DEL_FRONT: begin
                            if (empty) begin
                                n_res.status = STS_EMPTY;
                            end else begin
                                n_count = r_count - CNTW'(1);
                                do_del  = (cmd.op == OP_DEL_FRONT);
                            end
                        end
                        OP_DEL_POS: begin
                            if (pos_bad) begin
                                n_res.status = STS_RANGE;
                            end else begin
                                do_del  = 1'b1;
                                ep      = pos_e;
                                n_count = r_count - CNTW'(1);
                            end
                        end
                        OP_FIND: begin
                            n_res.found = |match;
                            n_res.index = fit_index(32'(f_idx));
                        end
                        OP_MODIFY: begin
                            if (pos_bad) begin
                                n_res.status = STS_RANGE;
                            end else begin
                                do_mod = 1'b1;
                                ep     = pos_e;
                            end
                        end
                        OP_DUMP: begin
                            if (!empty) begin
                                // first element goes out now, the rest follow
                                do_rot         = 1'b1;
                                n_res.data_out = out0;
                                n_res.last     = (r_count == CNTW'(1));
                                if (r_count != CNTW'(1)) begin
                                    n_state = BS_DUMP;
                                    n_didx  = IW'(1);
                                end
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BS_DUMP: begin
                n_strobe       = 1'b1;
                do_rot         = 1'b1;
                n_res.data_out = out0;
                n_res.index    = fit_index(32'(r_didx));
                n_res.last     = (CNTW'(r_didx) == r_count - CNTW'(1));
                if (n_res.last) begin
                    n_state = BS_RUN;
                    n_didx  = '0;
                end else begin
                    n_didx = r_didx + IW'(1);
                end
            end
            default: begin
                n_state = BS_RUN;
            end
        endcase
        n_res.count = fit_count(32'(n_count));
    end

    // per-cell next value: shift up, shift down, write or rotate
    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            localparam int PI = (i == 0) ? 0 : i - 1;
            localparam int NI = (i == CAPACITY - 1) ? i : i + 1;
            always_comb begin
                n_cell[i] = r_cell[i];
                if (do_ins) begin
                    if (EPW'(i) == ep) begin
                        n_cell[i] = key;
                    end else if (EPW'(i) > ep) begin
                        n_cell[i] = r_cell[PI];
                    end
                end else if (do_del) begin
                    if (EPW'(i) >= ep) begin
                        n_cell[i] = r_cell[NI];
                    end
                end else if (do_mod) begin
                    if (EPW'(i) == ep) begin
                        n_cell[i] = key;
                    end
                end else if (do_rot) begin
                    if (EPW'(i) == cnt_e - EPW'(1)) begin
                        n_cell[i] = r_cell[0];
                    end else begin
                        n_cell[i] = r_cell[NI];
                    end
                end
            end
        end
    endgenerate

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_RUN;
            r_count  <= '0;
            r_didx   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_didx   <= n_didx;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        r_res  <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

// ===== hdl/sequential_list_engine.sv =====
// ----------------------------------------------------------------------------
// sequential_list_engine
// Fixed-capacity ordered list of signed words with push, pop, insert, erase,
// modify, find, clear and dump requests.
// ----------------------------------------------------------------------------
// Path: an item is queued, run by the cell chain from the queue head and its
//   result strobed from a register; later while earlier items are queued.
// Throughput: one item per cycle while busy is low, through a two-item queue
//   into the cell chain; a dump holds the chain until its last element is out.
// Reset: synchronous; the list comes up empty, stored words stay undefined.
module sequential_list_engine #(
    parameter int unsigned CAPACITY   = sle_pkg::CAPACITY_DEF,
    parameter int unsigned DATA_WIDTH = sle_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  sle_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output sle_pkg::t_res o_res
);
    import sle_pkg::*;

    t_qhead head;
    logic   pop;

    // request decode and queue
    sle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .o_busy  (busy),
        .i_pop   (pop),
        .o_head  (head)
    );

    // list storage and execution
    sle_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule

// ===== hdl/sle_checker.sv =====
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks on the list engine's result stream.
// ----------------------------------------------------------------------------
`include "sequential_list_engine_defines.svh"

module sle_checker #(
    parameter int unsigned CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_strobe,
    input sle_pkg::t_res o_res
);
    import sle_pkg::*;

    logic res_more;
    logic res_reject;
    logic res_hit;
    logic res_hit_ok;
    logic res_in_cap;

    // result stream views
    assign res_more   = o_strobe && !o_res.last;
    assign res_reject = o_strobe && (o_res.status != STS_OK);
    assign res_hit    = o_strobe && o_res.found;
    assign res_hit_ok = (o_res.status == STS_OK) && (o_res.count != 5'd0);
    assign res_in_cap = (CAPACITY >= 32) || (32'(o_res.count) <= CAPACITY);

    // a dump runs without gaps until its final item
    `SLE_ASSERT_NEXT(a_dump_gapless, i_clk, i_rst_n, res_more, o_strobe)

    // a rejected request gives exactly one item
    `SLE_ASSERT_IMPLY(a_reject_single, i_clk, i_rst_n, res_reject, o_res.last)

    // a match is only reported on a successful request
    `SLE_ASSERT_IMPLY(a_found_ok, i_clk, i_rst_n, res_hit, res_hit_ok)

    // count never exceeds the capacity
    `SLE_ASSERT_IMPLY(a_count_cap, i_clk, i_rst_n, o_strobe, res_in_cap)

endmodule

bind sequential_list_engine sle_checker #(
    .CAPACITY (CAPACITY)
) u_sle_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);
